// ===== sv/atq_pkg.sv =====
// ----------------------------------------------------------------------------
// atq_pkg: adaptive threshold quantizer shared definitions
// Sizes, field widths, threshold types and reset values used by the quantizer
// top level and its threshold update logic.
// ----------------------------------------------------------------------------
package atq_pkg;

    localparam int unsigned CHANNELS   = 32;
    localparam int unsigned CUTS       = 3;
    localparam int unsigned FULL_SCALE = 65535;
    localparam int unsigned ETA_RESET  = 256;

    localparam int unsigned CH_W     = 5;
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned THR_W    = 16;
    localparam int unsigned ETA_W    = 16;
    localparam int unsigned CODE_W   = 2;
    localparam int unsigned CNT_W    = $clog2(CUTS + 1);

    localparam int unsigned IN_DATA_W  = ((CH_W + SAMPLE_W + 7) / 8) * 8;
    localparam int unsigned OUT_DATA_W = ((CH_W + CODE_W + 7) / 8) * 8;

    // only channels that the channel field can address get storage
    localparam int unsigned ROWS  = (CHANNELS < (1 << CH_W)) ? CHANNELS : (1 << CH_W);
    localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    localparam int unsigned SPACING = FULL_SCALE / (CUTS + 1);

    typedef logic [THR_W-1:0]    thr_t;
    typedef thr_t [CUTS-1:0]     row_t;
    typedef logic [ETA_W-1:0]    step_t;
    typedef step_t [CUTS-1:0]    step_vec_t;
    typedef logic [CODE_W-1:0]   code_t;
    typedef logic [CH_W-1:0]     chan_t;
    typedef logic [SAMPLE_W-1:0] sample_t;

endpackage

// ===== sv/adaptive_threshold_quantizer.sv =====
// ----------------------------------------------------------------------------
// adaptive_threshold_quantizer: per-channel adaptive quantizer
// Quantizes 16-bit samples against per-channel thresholds that adapt toward
// the sample distribution, and returns the number of thresholds met.
//
//   port group  direction  payload (lowest bit first)
//   s_axis      in         channel[4:0], sample[20:5], zero pad to 24 bits
//   m_axis      out        channel_out[4:0], code[6:5], zero pad to 8 bits
//   cfg         in         eta[15:0]
//
// One item per cycle sustained unless m_axis stalls; an accepted item
// goes from the input register to the result register; the row read, compare,
// step and write-back occur on that move, so consecutive same-channel items see
// the update. Reset loads all thresholds to their evenly spaced start values
// at once and eta to 256. A stalled result holds; the input register still
// takes an item while the result register drains in the same cycle.
// ----------------------------------------------------------------------------
module adaptive_threshold_quantizer
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [atq_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // channel, sample
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [atq_pkg::OUT_DATA_W-1:0]     m_axis_tdata,   // channel_out, code
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [atq_pkg::ETA_W-1:0]          cfg_data        // eta
);
    import atq_pkg::*;

    logic      in_valid_reg;
    chan_t     in_ch_reg;
    sample_t   in_smp_reg;
    logic      out_valid_reg;
    chan_t     out_ch_reg;
    code_t     out_code_reg;
    row_t      thr_reg [ROWS];
    step_vec_t up_step_reg;
    step_vec_t down_step_reg;

    logic            fire;
    logic            in_range;
    logic [ROW_W-1:0] row_idx;
    row_t            row_next;
    code_t           code_next;

    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;
    assign cfg_ready     = 1'b1;
    assign in_range      = (32'(in_ch_reg) < CHANNELS);
    assign row_idx       = ROW_W'(in_ch_reg);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'({out_code_reg, out_ch_reg});

    // per-threshold steps, divided by constants when eta is written
    for (genvar k = 0; k < CUTS; k++)
    begin : g_step
        localparam longint unsigned DIV_UP   = CUTS - k;
        localparam longint unsigned DIV_DN   = k + 1;
        localparam longint unsigned MUL_UP   = ((64'd1 << 32) + DIV_UP - 1) / DIV_UP;
        localparam longint unsigned MUL_DN   = ((64'd1 << 32) + DIV_DN - 1) / DIV_DN;
        localparam longint unsigned RST_UP   = ETA_RESET / DIV_UP;
        localparam longint unsigned RST_DN   = ETA_RESET / DIV_DN;

        logic [48:0] up_prod;
        logic [48:0] dn_prod;

        assign up_prod = 49'(cfg_data) * 49'(MUL_UP);
        assign dn_prod = 49'(cfg_data) * 49'(MUL_DN);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                up_step_reg[k]   <= ETA_W'(RST_UP);
                down_step_reg[k] <= ETA_W'(RST_DN);
            end
            else if (cfg_valid && cfg_ready)
            begin
                up_step_reg[k]   <= up_prod[47:32];
                down_step_reg[k] <= dn_prod[47:32];
            end
        end
    end

    atq_update u_update
    (
        .row       (thr_reg[row_idx]),
        .sample    (in_smp_reg),
        .up_step   (up_step_reg),
        .down_step (down_step_reg),
        .row_next  (row_next),
        .code      (code_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                for (int k = 0; k < CUTS; k++)
                begin
                    thr_reg[r][k] <= THR_W'((k + 1) * SPACING);
                end
            end
        end
        else if (fire && in_range)
        begin
            thr_reg[row_idx] <= row_next;
        end
    end

    // input register: advance on accept, drop when consumed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_ch_reg  <= s_axis_tdata[CH_W-1:0];
            in_smp_reg <= s_axis_tdata[CH_W+SAMPLE_W-1:CH_W];
        end
    end

    // result register: hold while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_ch_reg   <= in_ch_reg;
            out_code_reg <= in_range ? code_next : '0;
        end
    end

endmodule

// ===== sv/atq_update.sv =====
// ----------------------------------------------------------------------------
// atq_update: threshold row update
// Compares one sample with every threshold of a channel row, moves each
// threshold up or down by its step with saturation, and counts the thresholds
// met.
// ----------------------------------------------------------------------------
module atq_update
(
    input  atq_pkg::row_t      row,
    input  atq_pkg::sample_t   sample,
    input  atq_pkg::step_vec_t up_step,
    input  atq_pkg::step_vec_t down_step,
    output atq_pkg::row_t      row_next,
    output atq_pkg::code_t     code
);
    import atq_pkg::*;

    always_comb
    begin
        logic [THR_W:0] sum;
        logic [CNT_W-1:0] cnt;
        cnt = '0;
        sum = '0;
        for (int k = 0; k < CUTS; k++)
        begin
            if (sample >= row[k])
            begin
                sum = {1'b0, row[k]} + {1'b0, up_step[k]};
                row_next[k] = sum[THR_W] ? THR_W'(FULL_SCALE) : sum[THR_W-1:0];
                cnt = cnt + CNT_W'(1);
            end
            else
            begin
                row_next[k] = (down_step[k] > row[k]) ? '0 : row[k] - down_step[k];
            end
        end
        code = CODE_W'(cnt);
    end

endmodule
